// ===== rtl/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared types, event codes and helpers for the CSV byte tokenizer.
// ----------------------------------------------------------------------------
package cbt_pkg;

   localparam int MaxEv      = 6;
   localparam int EvCntW     = $clog2(MaxEv + 1);
   localparam int EvIdxW     = $clog2(MaxEv);
   localparam int QueueDepth = 4;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCntW      = $clog2(QueueDepth + 1);

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   localparam logic [2:0] KIND_BYTE   = 3'd0;
   localparam logic [2:0] KIND_FEND   = 3'd1;
   localparam logic [2:0] KIND_REND   = 3'd2;
   localparam logic [2:0] KIND_EQUOTE = 3'd3;
   localparam logic [2:0] KIND_NOROWS = 3'd4;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] fbyte;
   } event_type;

   typedef struct packed {
      logic [EvCntW-1:0]       count;
      event_type [MaxEv-1:0]   ev;
   } bundle_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic [7:0] bom_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'hEF;
         2'd1:    val = 8'hBB;
         2'd2:    val = 8'hBF;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   function automatic bundle_type push_ev(input bundle_type bin, input logic [2:0] kind,
                                          input logic [7:0] fbyte);
      bundle_type bout;
      bout = bin;
      if (bin.count < EvCntW'(MaxEv)) begin
         bout.ev[bin.count[EvIdxW-1:0]].kind  = kind;
         bout.ev[bin.count[EvIdxW-1:0]].fbyte = (kind == KIND_BYTE) ? fbyte : 8'h00;
         bout.count = bin.count + EvCntW'(1);
      end
      return bout;
   endfunction

endpackage

// ===== rtl/cbt_front.sv =====
// ----------------------------------------------------------------------------
// cbt_front
// Accepts request bytes, runs the tokenizer flags and packs each request's
// events into one bundle for the queue.
// ----------------------------------------------------------------------------
module cbt_front import cbt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_data_byte,
   input  logic             req_end_of_stream,
   input  queue_status_type q_status,
   output logic             push,
   output bundle_type       push_bundle
);

   logic       inside_quotes_ff, inside_quotes_in;
   logic       quote_pending_ff, quote_pending_in;
   logic       cr_pending_ff, cr_pending_in;
   logic       row_ended_ff, row_ended_in;
   logic       field_content_ff, field_content_in;
   logic       any_row_ff, any_row_in;
   logic [1:0] bom_count_ff, bom_count_in;
   logic       bom_open_ff, bom_open_in;
   logic       accept;
   bundle_type bundle;

   assign req_stall   = q_status.full;
   assign accept      = req_valid && !q_status.full;
   assign push        = accept && (bundle.count != '0);
   assign push_bundle = bundle;

   always_comb begin
      logic       iq, qp, crp, rhef, fhc, are, bwo;
      logic [1:0] bmc;
      logic       consumed, do_content, main_end, main_rend;
      logic [7:0] b;
      bundle_type bl;

      b    = req_data_byte;
      iq   = inside_quotes_ff;
      qp   = quote_pending_ff;
      crp  = cr_pending_ff;
      rhef = row_ended_ff;
      fhc  = field_content_ff;
      are  = any_row_ff;
      bmc  = bom_count_ff;
      bwo  = bom_open_ff;
      bl   = '0;
      consumed   = 1'b0;
      do_content = 1'b0;
      main_end   = 1'b0;
      main_rend  = 1'b0;

      if (crp) begin
         crp = 1'b0;
         if (b == CH_LF) consumed = 1'b1;
      end
      if (!consumed && qp) begin
         qp = 1'b0;
         if (b == CH_QUOTE) begin
            do_content = 1'b1;
            consumed   = 1'b1;
         end else begin
            iq = 1'b0;
         end
      end
      if (!consumed) begin
         if (b == CH_QUOTE) begin
            if (iq) qp = 1'b1;
            else    iq = 1'b1;
         end else if (!iq && b == CH_COMMA) begin
            main_end = 1'b1;
         end else if (!iq && (b == CH_CR || b == CH_LF)) begin
            if (rhef || fhc) begin
               main_end  = 1'b1;
               main_rend = 1'b1;
            end
            if (b == CH_CR) crp = 1'b1;
         end else begin
            do_content = 1'b1;
         end
      end

      // content byte with BOM prefix handling
      if (do_content) begin
         fhc = 1'b1;
         if (!bwo) begin
            bl = push_ev(bl, KIND_BYTE, b);
         end else if (b == bom_byte(bmc)) begin
            if (bmc == 2'd2) begin
               bmc = 2'd0;
               bwo = 1'b0;
            end else begin
               bmc = bmc + 2'd1;
            end
         end else begin
            if (bmc > 2'd0) bl = push_ev(bl, KIND_BYTE, bom_byte(2'd0));
            if (bmc > 2'd1) bl = push_ev(bl, KIND_BYTE, bom_byte(2'd1));
            bmc = 2'd0;
            bl  = push_ev(bl, KIND_BYTE, b);
            bwo = 1'b0;
         end
      end

      if (main_end) begin
         if (bmc > 2'd0) bl = push_ev(bl, KIND_BYTE, bom_byte(2'd0));
         if (bmc > 2'd1) bl = push_ev(bl, KIND_BYTE, bom_byte(2'd1));
         bmc = 2'd0;
         bl  = push_ev(bl, KIND_FEND, 8'h00);
         bwo = 1'b0;
         if (main_rend) begin
            bl  = push_ev(bl, KIND_REND, 8'h00);
            are = 1'b1;
            rhef = 1'b0;
         end else begin
            rhef = 1'b1;
         end
         fhc = 1'b0;
      end else if (!consumed && !iq && (b == CH_CR || b == CH_LF)) begin
         rhef = 1'b0;
         fhc  = 1'b0;
      end

      if (req_end_of_stream) begin
         if (qp) begin
            qp = 1'b0;
            iq = 1'b0;
         end
         if (iq) begin
            bl = push_ev(bl, KIND_EQUOTE, 8'h00);
         end else begin
            if (fhc || rhef) begin
               if (bmc > 2'd0) bl = push_ev(bl, KIND_BYTE, bom_byte(2'd0));
               if (bmc > 2'd1) bl = push_ev(bl, KIND_BYTE, bom_byte(2'd1));
               bl  = push_ev(bl, KIND_FEND, 8'h00);
               bl  = push_ev(bl, KIND_REND, 8'h00);
               are = 1'b1;
            end
            if (!are) bl = push_ev(bl, KIND_NOROWS, 8'h00);
         end
         iq   = 1'b0;
         qp   = 1'b0;
         crp  = 1'b0;
         rhef = 1'b0;
         fhc  = 1'b0;
         are  = 1'b0;
         bmc  = 2'd0;
         bwo  = 1'b1;
      end

      inside_quotes_in = iq;
      quote_pending_in = qp;
      cr_pending_in    = crp;
      row_ended_in     = rhef;
      field_content_in = fhc;
      any_row_in       = are;
      bom_count_in     = bmc;
      bom_open_in      = bwo;
      bundle           = bl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_quotes_ff <= 1'b0;
         quote_pending_ff <= 1'b0;
         cr_pending_ff    <= 1'b0;
         row_ended_ff     <= 1'b0;
         field_content_ff <= 1'b0;
         any_row_ff       <= 1'b0;
         bom_count_ff     <= 2'd0;
         bom_open_ff      <= 1'b1;
      end else if (accept) begin
         inside_quotes_ff <= inside_quotes_in;
         quote_pending_ff <= quote_pending_in;
         cr_pending_ff    <= cr_pending_in;
         row_ended_ff     <= row_ended_in;
         field_content_ff <= field_content_in;
         any_row_ff       <= any_row_in;
         bom_count_ff     <= bom_count_in;
         bom_open_ff      <= bom_open_in;
      end
   end

endmodule

// ===== rtl/cbt_queue.sv =====
// ----------------------------------------------------------------------------
// cbt_queue
// Short queue of event bundles between the front and back ends.
// ----------------------------------------------------------------------------
module cbt_queue import cbt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bundle_type       push_bundle,
   input  logic             pop,
   output bundle_type       head,
   output queue_status_type status
);

   bundle_type        entry_ff [QueueDepth];
   logic [QPtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QCntW'(QueueDepth));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + QCntW'(1);
      if (!do_push && do_pop) count_in = count_ff - QCntW'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_bundle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/cbt_back.sv =====
// ----------------------------------------------------------------------------
// cbt_back
// Walks the head bundle and presents its events one per response.
// ----------------------------------------------------------------------------
module cbt_back import cbt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  bundle_type       head,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [7:0]       rsp_field_byte,
   output logic             rsp_last
);

   logic [EvIdxW-1:0] pos_ff, pos_in;
   logic              fire;
   event_type         cur;

   assign cur            = head.ev[pos_ff];
   assign rsp_valid      = !q_status.empty;
   assign rsp_kind       = cur.kind;
   assign rsp_field_byte = cur.fbyte;
   assign rsp_last       = (EvCntW'(pos_ff) + EvCntW'(1)) == head.count;
   assign fire           = rsp_valid && !rsp_stall;
   assign pop            = fire && rsp_last;

   always_comb begin
      pos_in = pos_ff;
      if (fire) pos_in = rsp_last ? '0 : pos_ff + EvIdxW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== rtl/csv_byte_tokenizer.sv =====
// ----------------------------------------------------------------------------
// csv_byte_tokenizer
// Events of a request are registered in the queue as one bundle. Throughput:
// one request per cycle while each request makes at most one response and
// rsp_stall is low; a request with more holds the response port until all
// are taken; the four-bundle queue absorbs this. Requests with none pass free.
// Reset: synchronous, clears tokenizer flags and empties the queue.
// ----------------------------------------------------------------------------
module csv_byte_tokenizer import cbt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_stream,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_field_byte,
   output logic       rsp_last
);

   queue_status_type q_status;
   bundle_type       push_bundle;
   bundle_type       head;
   logic             push;
   logic             pop;

   cbt_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .q_status          (q_status),
      .push              (push),
      .push_bundle       (push_bundle)
   );

   cbt_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head        (head),
      .status      (q_status)
   );

   cbt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_field_byte (rsp_field_byte),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== rtl/cbt_checker.sv =====
// ----------------------------------------------------------------------------
// cbt_checker
// Port-level checks on the tokenizer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module cbt_checker import cbt_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_data_byte,
   input logic       req_end_of_stream,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_field_byte,
   input logic       rsp_last
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data_byte)
         && $stable(req_end_of_stream))
      else $error("request changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_field_byte) && $stable(rsp_last))
      else $error("response changed while stalled");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_EQUOTE || rsp_kind == KIND_NOROWS) |-> rsp_last)
      else $error("error response not last of its request");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_BYTE |-> rsp_field_byte == 8'h00)
      else $error("field byte nonzero on a non-byte response");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid && !req_stall)
      else $error("queue not empty after reset");

endmodule

bind csv_byte_tokenizer cbt_checker u_checker (.*);
